// ----- design/mrlp_pkg.sv -----
// package for the modem response line parser
// types, codes and tag tables shared by the controller, datapath and top level
`timescale 1ns / 1ps

package mrlp_pkg;

    localparam int LINE_MAX = 64;
    localparam int ADDR_W   = $clog2(LINE_MAX);

    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_MO_QUEUE = 2'd1;
    localparam logic [1:0] FUNC_SESSION  = 2'd2;
    localparam logic [1:0] FUNC_MT_TAKEN = 2'd3;

    localparam logic [2:0] KIND_OTHER     = 3'd0;
    localparam logic [2:0] KIND_SBDIX_OK  = 3'd1;
    localparam logic [2:0] KIND_SBDIX_BAD = 3'd2;
    localparam logic [2:0] KIND_RING      = 3'd3;
    localparam logic [2:0] KIND_SIGNAL    = 3'd4;
    localparam logic [2:0] KIND_NETWORK   = 3'd5;

    localparam logic [2:0] FLD_MO    = 3'd0;
    localparam logic [2:0] FLD_SKIP1 = 3'd1;
    localparam logic [2:0] FLD_MT    = 3'd2;
    localparam logic [2:0] FLD_SKIP2 = 3'd3;
    localparam logic [2:0] FLD_LEN   = 3'd4;
    localparam logic [2:0] FLD_Q     = 3'd5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int TAG_REPORT_LEN = 7;
    localparam int TAG_RING_LEN   = 7;
    localparam int TAG_IND_LEN    = 6;
    localparam int POS_IND_SEL    = 6;
    localparam int POS_IND_VAL    = 8;
    localparam int ACC_CLAMP      = 40000;
    localparam int MO_OK_MAX      = 4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic               line_done;
        logic [2:0]         line_kind;
        logic signed [15:0] mo_status;
        logic signed [15:0] mt_status;
        logic signed [15:0] mt_length;
        logic signed [15:0] messages_waiting;
        logic signed [15:0] gateway_queued;
        logic signed [15:0] session_result;
        logic               ring_flag;
        logic [3:0]         signal_level;
        logic               net_up;
        logic               clear_mo_request;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic fin;
        logic apply;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic line_end;
        logic scan_last;
        logic out_free;
    } ctl_sts_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SCAN,
        C_TAIL,
        C_FIN,
        C_APPLY,
        C_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        P_WS,
        P_DIG,
        P_NUM,
        P_SKIP,
        P_OK,
        P_FAIL
    } parse_state_t;

    function automatic logic [7:0] tag_report(input logic [2:0] i);
        case (i)
            3'd0:    return "+";
            3'd1:    return "S";
            3'd2:    return "B";
            3'd3:    return "D";
            3'd4:    return "I";
            3'd5:    return "X";
            3'd6:    return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tag_ring(input logic [2:0] i);
        case (i)
            3'd0:    return "S";
            3'd1:    return "B";
            3'd2:    return "D";
            3'd3:    return "R";
            3'd4:    return "I";
            3'd5:    return "N";
            3'd6:    return "G";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tag_ind(input logic [2:0] i);
        case (i)
            3'd0:    return "+";
            3'd1:    return "C";
            3'd2:    return "I";
            3'd3:    return "E";
            3'd4:    return "V";
            3'd5:    return ":";
            default: return 8'h00;
        endcase
    endfunction

    // magnitude with sign to saturated 16-bit value
    function automatic logic signed [15:0] sat_num(input logic [15:0] a, input logic n);
        if (!n)
        begin
            return (a > 16'd32767) ? 16'sh7fff : signed'(a);
        end
        return (a > 16'd32768) ? 16'sh8000 : signed'(16'd0 - a);
    endfunction

endpackage

// ----- design/mrlp_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mrlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mrlp_datapath.sv -----
// datapath: line assembly, line store, character scan, field parse, status registers
// depends on mrlp_pkg and mrlp_ram
`timescale 1ns / 1ps

module mrlp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrlp_pkg::in_item_t   req,
    input  mrlp_pkg::ctl_cmd_t   cmd,
    output mrlp_pkg::ctl_sts_t   sts,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mrlp_pkg::out_item_t  rsp
);
    import mrlp_pkg::*;

    localparam logic [ADDR_W-1:0] LEN_WRAP = ADDR_W'(LINE_MAX - 1);

    logic [ADDR_W-1:0] len_reg, trail_reg, llen_reg, ptr_reg, pos_reg;
    logic              prev_cr_reg, dvalid_reg;
    logic              m_rep_reg, m_ring_reg, m_ind_reg, c6z_reg, c8v_reg;
    logic [7:0]        c8_reg;

    parse_state_t       pst_reg, pst_next;
    logic [2:0]         fld_reg, fld_next;
    logic               neg_reg, neg_next;
    logic [15:0]        acc_reg, acc_next;
    logic signed [15:0] mo_v_reg, mt_v_reg, ln_v_reg, q_v_reg;
    logic               store;

    logic               mo_pend_reg, ring_reg, net_reg;
    logic signed [15:0] wait_reg, mtlen_reg, gw_reg, mtst_reg, most_reg, res_reg;
    logic [3:0]         sig_reg;
    logic               done_reg, clr_reg;
    logic [2:0]         kind_reg;

    logic      rsp_valid_reg;
    out_item_t rsp_reg;

    logic              is_byte, b_crlf, drop, end_hit, ram_we;
    logic [ADDR_W-1:0] len_eff, len_inc, trail_inc;
    logic [7:0]        ch;
    logic              ch_digit, ch_ws, advance, step;
    logic [3:0]        dval;
    logic [19:0]       prod;
    logic [15:0]       acc_new;
    logic signed [15:0] numval;
    logic              sb, rg, cv, ok, c8_digit;

    mrlp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_eff),
        .wdata (req.rx_byte),
        .raddr (ptr_reg),
        .rdata (ch)
    );

    // line assembly
    assign is_byte   = (req.func == FUNC_BYTE);
    assign b_crlf    = (req.rx_byte == CH_CR) || (req.rx_byte == CH_LF);
    assign len_eff   = (len_reg >= LEN_WRAP) ? '0 : len_reg;
    assign drop      = (len_eff == '0) && b_crlf;
    assign len_inc   = len_eff + ADDR_W'(1);
    assign trail_inc = b_crlf ? trail_reg + ADDR_W'(1) : '0;
    assign end_hit   = is_byte && !drop && (req.rx_byte == CH_LF) && (len_eff != '0)
                       && prev_cr_reg;
    assign ram_we    = cmd.accept && is_byte && !drop;

    assign sts.line_end  = end_hit;
    assign sts.scan_last = (ptr_reg == llen_reg - ADDR_W'(1));
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    // character classes and number step
    assign ch_digit = (ch inside {[CH_ZERO:CH_NINE]});
    assign ch_ws    = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
    assign dval     = ch[3:0];
    assign prod     = (20'(acc_reg) << 3) + (20'(acc_reg) << 1) + 20'(dval);
    assign acc_new  = (prod > 20'(ACC_CLAMP)) ? 16'(ACC_CLAMP) : prod[15:0];
    assign numval   = sat_num(acc_reg, neg_reg);
    assign step     = (dvalid_reg && (pos_reg >= ADDR_W'(TAG_REPORT_LEN))) || cmd.fin;

    always_comb
    begin
        pst_next = pst_reg;
        fld_next = fld_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        store    = 1'b0;
        advance  = 1'b0;
        case (pst_reg)
            P_WS:
            begin
                if (cmd.fin)
                begin
                    pst_next = P_FAIL;
                end
                else if (ch_ws)
                begin
                    pst_next = P_WS;
                end
                else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                begin
                    neg_next = (ch == CH_MINUS);
                    pst_next = P_DIG;
                end
                else if (ch_digit)
                begin
                    neg_next = 1'b0;
                    acc_next = 16'(dval);
                    pst_next = P_NUM;
                end
                else
                begin
                    pst_next = P_FAIL;
                end
            end
            P_DIG:
            begin
                if (cmd.fin || !ch_digit)
                begin
                    pst_next = P_FAIL;
                end
                else
                begin
                    acc_next = 16'(dval);
                    pst_next = P_NUM;
                end
            end
            P_NUM:
            begin
                store = 1'b1;
                if (cmd.fin)
                begin
                    pst_next = (fld_reg == FLD_Q) ? P_OK : P_FAIL;
                end
                else if (ch_digit)
                begin
                    store    = 1'b0;
                    acc_next = acc_new;
                end
                else if (ch == CH_COMMA)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    pst_next = P_FAIL;
                end
            end
            P_SKIP:
            begin
                if (cmd.fin)
                begin
                    pst_next = P_FAIL;
                end
                else if (ch == CH_COMMA)
                begin
                    fld_next = fld_reg + 3'd1;
                    pst_next = P_WS;
                end
            end
            default:
            begin
                pst_next = pst_reg;
            end
        endcase
        if (advance)
        begin
            if (fld_reg == FLD_Q)
            begin
                pst_next = P_OK;
            end
            else
            begin
                fld_next = fld_reg + 3'd1;
                pst_next = (fld_reg == FLD_LEN) ? P_WS : P_SKIP;
            end
        end
    end

    // classification
    assign sb       = m_rep_reg && (llen_reg >= ADDR_W'(TAG_REPORT_LEN));
    assign rg       = m_ring_reg && (llen_reg == ADDR_W'(TAG_RING_LEN));
    assign cv       = m_ind_reg && (llen_reg >= ADDR_W'(TAG_IND_LEN));
    assign ok       = (pst_reg == P_OK);
    assign c8_digit = c8v_reg && (c8_reg inside {[CH_ZERO:CH_NINE]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            trail_reg     <= '0;
            prev_cr_reg   <= 1'b0;
            llen_reg      <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            dvalid_reg    <= 1'b0;
            m_rep_reg     <= 1'b0;
            m_ring_reg    <= 1'b0;
            m_ind_reg     <= 1'b0;
            c6z_reg       <= 1'b0;
            c8v_reg       <= 1'b0;
            c8_reg        <= '0;
            pst_reg       <= P_WS;
            fld_reg       <= FLD_MO;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            mo_v_reg      <= '0;
            mt_v_reg      <= '0;
            ln_v_reg      <= '0;
            q_v_reg       <= '0;
            mo_pend_reg   <= 1'b0;
            ring_reg      <= 1'b0;
            net_reg       <= 1'b0;
            wait_reg      <= '0;
            mtlen_reg     <= '0;
            gw_reg        <= '0;
            mtst_reg      <= '0;
            most_reg      <= '0;
            res_reg       <= 16'sd1;
            sig_reg       <= '0;
            done_reg      <= 1'b0;
            clr_reg       <= 1'b0;
            kind_reg      <= KIND_OTHER;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dvalid_reg <= cmd.issue;

            if (cmd.accept)
            begin
                done_reg <= 1'b0;
                clr_reg  <= 1'b0;
                kind_reg <= KIND_OTHER;
                case (req.func)
                    FUNC_BYTE:
                    begin
                        if (drop)
                        begin
                            len_reg <= len_eff;
                        end
                        else if (end_hit)
                        begin
                            len_reg    <= '0;
                            llen_reg   <= len_inc - trail_inc;
                            ptr_reg    <= '0;
                            m_rep_reg  <= 1'b1;
                            m_ring_reg <= 1'b1;
                            m_ind_reg  <= 1'b1;
                            c6z_reg    <= 1'b0;
                            c8v_reg    <= 1'b0;
                            pst_reg    <= P_WS;
                            fld_reg    <= FLD_MO;
                            neg_reg    <= 1'b0;
                        end
                        else
                        begin
                            len_reg     <= len_inc;
                            trail_reg   <= trail_inc;
                            prev_cr_reg <= (req.rx_byte == CH_CR);
                        end
                    end
                    FUNC_MO_QUEUE:
                    begin
                        mo_pend_reg <= 1'b1;
                    end
                    FUNC_SESSION:
                    begin
                        ring_reg <= 1'b0;
                    end
                    default:
                    begin
                        mtlen_reg <= '0;
                        if (wait_reg != 16'sh8000)
                        begin
                            wait_reg <= wait_reg - 16'sd1;
                        end
                    end
                endcase
            end

            if (cmd.issue)
            begin
                ptr_reg <= ptr_reg + ADDR_W'(1);
                pos_reg <= ptr_reg;
            end

            // prefix match and indicator positions
            if (dvalid_reg)
            begin
                if (pos_reg < ADDR_W'(TAG_REPORT_LEN))
                begin
                    if (ch != tag_report(pos_reg[2:0]))
                    begin
                        m_rep_reg <= 1'b0;
                    end
                    if (ch != tag_ring(pos_reg[2:0]))
                    begin
                        m_ring_reg <= 1'b0;
                    end
                end
                if ((pos_reg < ADDR_W'(TAG_IND_LEN)) && (ch != tag_ind(pos_reg[2:0])))
                begin
                    m_ind_reg <= 1'b0;
                end
                if (pos_reg == ADDR_W'(POS_IND_SEL))
                begin
                    c6z_reg <= (ch == CH_ZERO);
                end
                if (pos_reg == ADDR_W'(POS_IND_VAL))
                begin
                    c8v_reg <= 1'b1;
                    c8_reg  <= ch;
                end
            end

            // report field parse
            if (step)
            begin
                pst_reg <= pst_next;
                fld_reg <= fld_next;
                neg_reg <= neg_next;
                acc_reg <= acc_next;
                if (store)
                begin
                    case (fld_reg)
                        FLD_MO:  mo_v_reg <= numval;
                        FLD_MT:  mt_v_reg <= numval;
                        FLD_LEN: ln_v_reg <= numval;
                        FLD_Q:   q_v_reg  <= numval;
                        default: q_v_reg  <= q_v_reg;
                    endcase
                end
            end

            if (cmd.accept && end_hit)
            begin
                mo_v_reg <= '0;
            end

            if (cmd.apply)
            begin
                done_reg <= 1'b1;
                if (sb)
                begin
                    kind_reg <= ok ? KIND_SBDIX_OK : KIND_SBDIX_BAD;
                    if (ok)
                    begin
                        if (mt_v_reg == 16'sd1)
                        begin
                            wait_reg  <= (q_v_reg == 16'sh7fff) ? 16'sh7fff
                                                                : q_v_reg + 16'sd1;
                            mtlen_reg <= ln_v_reg;
                        end
                        gw_reg   <= q_v_reg;
                        mtst_reg <= mt_v_reg;
                    end
                    most_reg <= mo_v_reg;
                    if (mo_pend_reg && (mo_v_reg >= 16'sd0)
                        && (mo_v_reg <= 16'(MO_OK_MAX)))
                    begin
                        res_reg     <= 16'sd1;
                        mo_pend_reg <= 1'b0;
                        clr_reg     <= 1'b1;
                    end
                    else
                    begin
                        res_reg <= (mo_v_reg == 16'sh8000) ? 16'sh7fff : -mo_v_reg;
                    end
                end
                else if (rg)
                begin
                    ring_reg <= 1'b1;
                    kind_reg <= KIND_RING;
                end
                else if (cv)
                begin
                    if (c6z_reg)
                    begin
                        sig_reg  <= c8_digit ? c8_reg[3:0] : 4'd0;
                        kind_reg <= KIND_SIGNAL;
                    end
                    else
                    begin
                        if (c8v_reg && (c8_reg == CH_ONE))
                        begin
                            net_reg <= 1'b1;
                        end
                        else
                        begin
                            net_reg <= 1'b0;
                            sig_reg <= 4'd0;
                        end
                        kind_reg <= KIND_NETWORK;
                    end
                end
            end

            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.line_done        <= done_reg;
            rsp_reg.line_kind        <= kind_reg;
            rsp_reg.mo_status        <= most_reg;
            rsp_reg.mt_status        <= mtst_reg;
            rsp_reg.mt_length        <= mtlen_reg;
            rsp_reg.messages_waiting <= wait_reg;
            rsp_reg.gateway_queued   <= gw_reg;
            rsp_reg.session_result   <= res_reg;
            rsp_reg.ring_flag        <= ring_reg;
            rsp_reg.signal_level     <= sig_reg;
            rsp_reg.net_up           <= net_reg;
            rsp_reg.clear_mo_request <= clr_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- design/mrlp_ctrl.sv -----
// controller state machine: accept, line scan, apply, result hand-off
// depends on mrlp_pkg
`timescale 1ns / 1ps

module mrlp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  mrlp_pkg::ctl_sts_t sts,
    output mrlp_pkg::ctl_cmd_t cmd
);
    import mrlp_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            C_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.line_end ? C_SCAN : C_EMIT;
                end
            end
            C_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = C_TAIL;
                end
            end
            C_TAIL:
            begin
                state_next = C_FIN;
            end
            C_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = C_APPLY;
            end
            C_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = C_EMIT;
            end
            C_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

// ----- design/modem_response_line_parser.sv -----
// top level of the modem response line parser: controller plus datapath
// depends on mrlp_pkg, mrlp_ctrl and mrlp_datapath
// an item that does not end a line goes straight to the result hand-off; one that ends
// a line first has its stripped line (at most LINE_MAX - 3 bytes) scanned character by
// character, finished and applied; the input is held during the scan and while a result
// is stalled, and no new item is taken before the previous result has been handed off
// reset: rst_n asynchronous active low, clears status, line length and handshakes
`timescale 1ns / 1ps

module modem_response_line_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mrlp_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mrlp_pkg::out_item_t rsp
);
    import mrlp_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    mrlp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mrlp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
